>>> src/sgdma_pkg.sv
// ----------------------------------------------------------------------------
// sgdma_pkg
// shared types and constants of the dma engine register block
// ----------------------------------------------------------------------------
package sgdma_pkg;

    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_PROGRESS = 2'd2;
    localparam logic [1:0] OP_FINISH   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_READONLY = 2'd2;
    localparam logic [1:0] ST_UNIMPL   = 2'd3;

    localparam int NUM_CHANNELS = 2;

    localparam logic [31:0] ID_BASE     = 32'h1FC0_0005;
    localparam logic [31:0] ALIGN_VALUE = 32'h0001_0140;
    localparam logic [31:0] VEC_MASK    = 32'h1F1F_1F1F;
    localparam logic [27:0] CTRL_MASK   = 28'hFFF_FE7F;
    localparam logic [23:0] IEN_MASK    = 24'hFF_FFFE;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [31:0] write_data;
        logic        channel;
        logic [6:0]  completed_count;
    } sgdma_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  access_status;
        logic        start_pulse;
        logic        start_channel;
        logic [63:0] start_desc_address;
        logic [6:0]  start_desc_count;
        logic        irq_pulse;
        logic        irq_vector_out;
    } sgdma_out_t;

endpackage

>>> src/sgdma_regs.sv
// ----------------------------------------------------------------------------
// sgdma_regs
// register state, address decode and event update for one transaction a cycle while fire is high
// ----------------------------------------------------------------------------
module sgdma_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  sgdma_pkg::sgdma_in_t  item,
    output sgdma_pkg::sgdma_out_t result
);
    import sgdma_pkg::*;

    logic [27:0] ctrl_reg [2];
    logic [23:0] stat_reg [2];
    logic [31:0] done_reg [2];
    logic [23:0] ien_reg  [2];
    logic [63:0] desc_reg [2];
    logic [5:0]  adj_reg  [2];
    logic [31:0] uien_reg, cien_reg, creq_reg;
    logic [31:0] uvec_reg [4];
    logic [31:0] cvec_reg [2];

    logic [27:0] ctrl_next [2];
    logic [23:0] stat_next [2];
    logic [31:0] done_next [2];
    logic [23:0] ien_next  [2];
    logic [63:0] desc_next [2];
    logic [5:0]  adj_next  [2];
    logic [31:0] uien_next, cien_next, creq_next;
    logic [31:0] uvec_next [4];
    logic [31:0] cvec_next [2];

    logic [3:0]  region;
    logic [7:0]  off;
    logic [11:0] o12;
    logic        wr;
    logic        e;
    logic [31:0] wd;
    logic [31:0] rd;
    logic [1:0]  st;

    always_comb
    begin
        region = item.address[15:12];
        off    = item.address[7:0];
        o12    = item.address[11:0];
        wr     = (item.operation == OP_WRITE);
        e      = item.address[12];
        wd     = item.write_data;
        rd     = '0;
        st     = ST_OK;
        result = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            ctrl_next[i] = ctrl_reg[i];
            stat_next[i] = stat_reg[i];
            done_next[i] = done_reg[i];
            ien_next[i]  = ien_reg[i];
            desc_next[i] = desc_reg[i];
            adj_next[i]  = adj_reg[i];
            cvec_next[i] = cvec_reg[i];
        end
        for (int i = 0; i < 4; i++)
            uvec_next[i] = uvec_reg[i];
        uien_next = uien_reg;
        cien_next = cien_reg;
        creq_next = creq_reg;

        if (item.operation == OP_PROGRESS)
        begin
            done_next[item.channel] = done_reg[item.channel] + 32'(item.completed_count);
        end
        else if (item.operation == OP_FINISH)
        begin
            stat_next[item.channel][0] = 1'b0;
            if (cien_reg[item.channel])
            begin
                creq_next = 32'd1 << item.channel;
                result.irq_pulse      = 1'b1;
                result.irq_vector_out = item.channel;
            end
        end
        else
        begin
            case (region)
                4'd0, 4'd1:
                begin
                    if (wr)
                    begin
                        case (off)
                            8'h04:
                            begin
                                ctrl_next[e] = wd[27:0] & CTRL_MASK;
                                if (wd[0])
                                begin
                                    stat_next[e][0] = 1'b1;
                                    done_next[e] = '0;
                                    result.start_pulse = 1'b1;
                                    result.start_channel = e;
                                    result.start_desc_address = desc_reg[e];
                                    result.start_desc_count = 7'd1 + 7'(adj_reg[e]);
                                end
                            end
                            8'h08: ctrl_next[e] = ctrl_reg[e] | wd[27:0];
                            8'h0C: ctrl_next[e] = ctrl_reg[e] & ~wd[27:0];
                            8'h40: stat_next[e] = stat_reg[e] & ~{wd[23:1], 1'b0};
                            8'h90: ien_next[e] = wd[23:0] & IEN_MASK;
                            8'h94: ien_next[e] = (ien_reg[e] | wd[23:0]) & IEN_MASK;
                            8'h98: ien_next[e] = ien_reg[e] & ~wd[23:0] & IEN_MASK;
                            8'h88, 8'h8C, 8'hC0: st = ST_UNIMPL;
                            8'h00, 8'h4C, 8'hC8, 8'hCC, 8'hD0: st = ST_READONLY;
                            default: st = ST_INVALID;
                        endcase
                    end
                    else
                    begin
                        case (off)
                            8'h00: rd = ID_BASE | {15'd0, e, 16'd0};
                            8'h04, 8'h08, 8'h0C: rd = {4'd0, ctrl_reg[e]};
                            8'h40: rd = {8'd0, stat_reg[e]};
                            8'h44:
                            begin
                                rd = {8'd0, stat_reg[e]};
                                stat_next[e] = {23'd0, stat_reg[e][0]};
                            end
                            8'h48: rd = done_reg[e];
                            8'h4C: rd = ALIGN_VALUE;
                            8'h90, 8'h94, 8'h98: rd = {8'd0, ien_reg[e] & IEN_MASK};
                            8'h88, 8'h8C, 8'hC0, 8'hC4, 8'hC8, 8'hCC, 8'hD0: st = ST_UNIMPL;
                            default: st = ST_INVALID;
                        endcase
                    end
                end
                4'd2:
                begin
                    if (wr)
                    begin
                        case (off)
                            8'h04: uien_next = wd;
                            8'h08: uien_next = uien_reg | wd;
                            8'h0C: uien_next = uien_reg & ~wd;
                            8'h10: cien_next = wd;
                            8'h14: cien_next = cien_reg | wd;
                            8'h18: cien_next = cien_reg & ~wd;
                            8'h80, 8'h84, 8'h88, 8'h8C: uvec_next[off[3:2]] = wd & VEC_MASK;
                            8'hA0, 8'hA4: cvec_next[off[2]] = wd & VEC_MASK;
                            8'h00, 8'h40, 8'h44, 8'h48, 8'h4C: st = ST_READONLY;
                            default: st = ST_INVALID;
                        endcase
                    end
                    else
                    begin
                        case (off)
                            8'h00: rd = ID_BASE | 32'h0002_0000;
                            8'h04: rd = uien_reg;
                            8'h10: rd = cien_reg;
                            8'h40, 8'h48, 8'h4C: rd = '0;
                            8'h44: rd = creq_reg;
                            8'h80, 8'h84, 8'h88, 8'h8C: rd = uvec_reg[off[3:2]] & VEC_MASK;
                            8'hA0, 8'hA4: rd = cvec_reg[off[2]] & VEC_MASK;
                            default: st = ST_INVALID;
                        endcase
                    end
                end
                4'd3:
                begin
                    case (off)
                        8'h00:
                        begin
                            if (wr)
                                st = ST_READONLY;
                            else
                                rd = ID_BASE | 32'h0003_0000;
                        end
                        8'h04, 8'h08, 8'h0C, 8'h10, 8'h14, 8'h18:
                            st = wr ? ST_READONLY : ST_UNIMPL;
                        8'h1C, 8'h40, 8'h44, 8'h60: st = ST_UNIMPL;
                        default: st = ST_INVALID;
                    endcase
                end
                4'd4, 4'd5:
                begin
                    if (wr)
                    begin
                        case (off)
                            8'h80: desc_next[e][31:0] = wd;
                            8'h84: desc_next[e][63:32] = wd;
                            8'h88: adj_next[e] = wd[5:0];
                            8'h8C: st = ST_UNIMPL;
                            8'h00: st = ST_READONLY;
                            default: st = ST_INVALID;
                        endcase
                    end
                    else
                    begin
                        case (off)
                            8'h80: rd = desc_reg[e][31:0];
                            8'h84: rd = desc_reg[e][63:32];
                            8'h88: rd = {26'd0, adj_reg[e]};
                            8'h00, 8'h8C: st = ST_UNIMPL;
                            default: st = ST_INVALID;
                        endcase
                    end
                end
                4'd6:
                begin
                    case (off)
                        8'h00: st = wr ? ST_INVALID : ST_UNIMPL;
                        8'h10, 8'h14, 8'h18, 8'h20, 8'h24, 8'h28: st = ST_UNIMPL;
                        default: st = ST_INVALID;
                    endcase
                end
                4'd8:
                    st = (o12 <= 12'h1FC || o12 == 12'hFE0) ? ST_UNIMPL : ST_INVALID;
                default: st = ST_INVALID;
            endcase
            if (!wr && st != ST_OK)
                rd = '1;
            result.read_data     = wr ? 32'd0 : rd;
            result.access_status = st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ctrl_reg[i] <= '0;
                stat_reg[i] <= '0;
                done_reg[i] <= '0;
                ien_reg[i]  <= '0;
                desc_reg[i] <= '0;
                adj_reg[i]  <= '0;
                cvec_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
                uvec_reg[i] <= '0;
            uien_reg <= '0;
            cien_reg <= '0;
            creq_reg <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ctrl_reg[i] <= ctrl_next[i];
                stat_reg[i] <= stat_next[i];
                done_reg[i] <= done_next[i];
                ien_reg[i]  <= ien_next[i];
                desc_reg[i] <= desc_next[i];
                adj_reg[i]  <= adj_next[i];
                cvec_reg[i] <= cvec_next[i];
            end
            for (int i = 0; i < 4; i++)
                uvec_reg[i] <= uvec_next[i];
            uien_reg <= uien_next;
            cien_reg <= cien_next;
            creq_reg <= creq_next;
        end
    end

endmodule

>>> src/sg_dma_engine_register_block_core.sv
// ----------------------------------------------------------------------------
// sg_dma_engine_register_block_core
// register file of a two-channel scatter-gather dma engine
// ----------------------------------------------------------------------------
// one transaction a cycle: each bus read, bus write, progress or finish event
// is registered on input, decoded and applied to the register state in one
// pass, and its result lands in an output register. with the output taken
// every cycle a new transaction is accepted every cycle; the path runs
// through the input and output registers. the output register is refilled
// as it drains, so a stall downstream holds the input register, and new
// transactions wait only while both are full.
module sg_dma_engine_register_block_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sgdma_pkg::sgdma_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sgdma_pkg::sgdma_out_t out_data
);
    import sgdma_pkg::*;

    logic       hold_valid_reg;
    sgdma_in_t  hold_reg;
    logic       res_valid_reg;
    sgdma_out_t res_reg;
    sgdma_out_t result;
    logic       fire;

    // the held transaction updates state only when it moves to the output
    assign fire      = hold_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !hold_valid_reg || fire;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    sgdma_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (hold_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                hold_valid_reg <= in_valid;
            if (fire)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            hold_reg <= in_data;
        if (fire)
            res_reg <= result;
    end

endmodule
